FILE: hw/rtl/ilid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared widths, request and status codes, and the control/status structs
// that join the indexed list controller and datapath.
// ----------------------------------------------------------------------------
package ilid_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 16;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ       = 3'd0,
      FUNC_INS_HEAD   = 3'd1,
      FUNC_INS_TAIL   = 3'd2,
      FUNC_INS_POS    = 3'd3,
      FUNC_DELETE     = 3'd4
   } ilid_func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } ilid_status_type;

   // what the decoded request does to the list
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_READ   = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_DELETE = 2'd3
   } ilid_kind_type;

   typedef struct packed {
      logic load_req;
      logic init_cursor;
      logic mem_rd;
      logic step;
      logic drain;
      logic finish;
   } ilid_cmd_type;

   typedef struct packed {
      ilid_kind_type kind;
      logic          no_shift;
      logic          cursor_last;
      logic          rsp_free;
   } ilid_stat_type;

endpackage
`default_nettype wire

FILE: hw/rtl/ilid_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilid request and response channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface ilid_req_if;
   logic                                valid;
   logic                                ready;
   logic        [ilid_pkg::FUNC_W-1:0]  func;
   logic signed [ilid_pkg::POS_W-1:0]   position;
   logic signed [ilid_pkg::VALUE_W-1:0] item_value;

   modport source (output valid, func, position, item_value, input ready);
   modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface ilid_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ilid_pkg::VALUE_W-1:0]  read_value;
   logic        [ilid_pkg::STATUS_W-1:0] status;
   logic        [ilid_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, read_value, status, entry_count, input ready);
   modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/indexed_list_insert_delete_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Ordered list of up to CAPACITY signed 32-bit entries with read, insert and
// delete by position; one response transaction per request transaction.
//
// req_bus carries func, position and item_value; rsp_bus returns read_value,
// status and entry_count. Both are valid/ready channels.
// A request is taken only while the unit is idle. Entries live in a single
// port-pair memory, so every entry that moves on an insert or delete passes
// through the memory read and write ports.
// After the request transaction the unit decides; a request with no effect or
// with no entries to move then finishes, a successful read passes through a
// memory read first, and an insert or delete that moves entries walks them
// one by one and drains the last move before it finishes.
// The response appears in the output register on the cycle the unit becomes
// idle again; a new request is taken while it waits. If the receiver stalls,
// the unit holds the next finished response until the register frees up.
// Reset empties the list (count to zero) and drops any pending response;
// memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_unit #(
   parameter int CAPACITY = ilid_pkg::CAPACITY_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   ilid_req_if.sink    req_bus,
   ilid_rsp_if.source  rsp_bus
);
   import ilid_pkg::*;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   ilid_cmd_type  cmd;
   ilid_stat_type stat;

   ilid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ilid_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_bus.func),
      .req_position    (req_bus.position),
      .req_item_value  (req_bus.item_value),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_read_value  (rsp_bus.read_value),
      .rsp_status      (rsp_bus.status),
      .rsp_entry_count (rsp_bus.entry_count)
   );

`ifndef SYNTHESIS
   // a taken request keeps the unit busy on the following cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while previous one still in flight");

   // a finished request always lands in the output register
   a_finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_bus.valid)
      else $error("finished request did not produce a response");

   // refusal for a full list only happens at capacity
   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == ST_FULL)) |->
         (rsp_bus.entry_count == CAP_COUNT) && (rsp_bus.read_value == '0))
      else $error("full status with a count below capacity");

   // the move cursor only runs while a shift command is active
   a_step_needs_move: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ((stat.kind == KIND_INSERT) || (stat.kind == KIND_DELETE)))
      else $error("entry move issued for a request that moves nothing");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/ilid_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_ctrl
// Sequencer for the indexed list: accepts a request, walks the entry moves
// one per cycle, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ilid_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ilid_pkg::ilid_stat_type stat,
   output ilid_pkg::ilid_cmd_type      cmd
);
   import ilid_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECIDE = 6'b000010,
      S_READ   = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_DRAIN  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            unique case (stat.kind)
               KIND_NONE:   state_in = S_FINISH;
               KIND_READ:   state_in = S_READ;
               KIND_INSERT,
               KIND_DELETE: state_in = stat.no_shift ? S_FINISH : S_SHIFT;
               default:     state_in = S_FINISH;
            endcase
         end
         S_READ: begin
            state_in = S_FINISH;
         end
         S_SHIFT: begin
            if (stat.cursor_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign cmd.load_req    = (state_ff == S_IDLE) && req_valid;
   assign cmd.init_cursor = (state_ff == S_DECIDE);
   assign cmd.mem_rd      = (state_ff == S_READ) || (state_ff == S_SHIFT);
   assign cmd.step        = (state_ff == S_SHIFT);
   assign cmd.drain       = (state_ff == S_DRAIN);
   // hold in finish until the output register can take the result
   assign cmd.finish      = (state_ff == S_FINISH) && stat.rsp_free;

endmodule
`default_nettype wire

FILE: hw/rtl/ilid_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_dpath
// Entry memory, entry count, move cursor, request decode and the result
// output register of the indexed list.
// ----------------------------------------------------------------------------
module ilid_dpath #(
   parameter int CAPACITY = ilid_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ilid_pkg::ilid_cmd_type              cmd,
   output ilid_pkg::ilid_stat_type                  stat,
   input  wire logic        [ilid_pkg::FUNC_W-1:0]  req_func,
   input  wire logic signed [ilid_pkg::POS_W-1:0]   req_position,
   input  wire logic signed [ilid_pkg::VALUE_W-1:0] req_item_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [ilid_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic        [ilid_pkg::STATUS_W-1:0]     rsp_status,
   output logic        [ilid_pkg::COUNT_W-1:0]      rsp_entry_count
);
   import ilid_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW + 1 > POS_W + 1) ? CW + 1 : POS_W + 1;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   logic signed [VALUE_W-1:0] slots_mem [CAPACITY];

   logic        [FUNC_W-1:0]  func_ff,  func_in;
   logic signed [POS_W-1:0]   pos_ff,   pos_in;
   logic signed [VALUE_W-1:0] val_ff,   val_in;
   logic        [CW-1:0]      count_ff, count_in;
   logic        [AW-1:0]      cursor_ff, cursor_in;
   logic        [AW-1:0]      dst_ff,   dst_in;
   logic                      pend_ff,  pend_in;
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic        [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic        [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   ilid_kind_type             kind;
   ilid_status_type           status;
   logic                      rv_ones;
   logic        [AW-1:0]      target;
   logic signed [CMPW-1:0]    pos_s;
   logic signed [CMPW-1:0]    cnt_s;
   logic        [AW-1:0]      target_clip;
   logic                      full;
   logic        [CW-1:0]      count_m1;
   logic        [AW-1:0]      last_addr;
   logic        [CW+COUNT_W-1:0] count_wide;

   logic                      wr_en;
   logic        [AW-1:0]      wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   // request decode against the current count
   always_comb begin
      pos_s       = CMPW'(pos_ff);
      cnt_s       = signed'(CMPW'(count_ff));
      full        = (count_ff == CAP_CNT);
      target_clip = pos_ff[POS_W-1] ? '0 : pos_s[AW-1:0];
      kind        = KIND_NONE;
      status      = ST_DONE;
      rv_ones     = 1'b0;
      target      = '0;
      unique case (func_ff)
         FUNC_READ: begin
            if ((count_ff == '0) || (pos_s >= cnt_s)) begin
               status  = ST_RANGE;
               rv_ones = 1'b1;
            end else begin
               kind   = KIND_READ;
               target = target_clip;
            end
         end
         FUNC_INS_HEAD: begin
            if (full) status = ST_FULL;
            else kind = KIND_INSERT;
         end
         FUNC_INS_TAIL: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               kind   = KIND_INSERT;
               target = count_ff[AW-1:0];
            end
         end
         FUNC_INS_POS: begin
            if (pos_s > cnt_s) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               kind   = KIND_INSERT;
               target = target_clip;
            end
         end
         FUNC_DELETE: begin
            if (pos_ff[POS_W-1] || (pos_s >= cnt_s)) begin
               status = ST_RANGE;
            end else begin
               kind   = KIND_DELETE;
               target = pos_s[AW-1:0];
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   assign count_m1  = count_ff - 1'b1;
   assign last_addr = (kind == KIND_INSERT) ? target : count_m1[AW-1:0];

   assign stat.kind        = kind;
   assign stat.no_shift    = (kind == KIND_INSERT) ? (CW'(target) == count_ff)
                                                   : (CW'(target) == count_m1);
   assign stat.cursor_last = (cursor_ff == last_addr);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   // memory write port: pending move, or the inserted value at the end
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = dst_ff;
      wr_data = rd_data_ff;
      if ((cmd.step && pend_ff) || cmd.drain) begin
         wr_en = 1'b1;
      end else if (cmd.finish && (kind == KIND_INSERT)) begin
         wr_en   = 1'b1;
         wr_addr = target;
         wr_data = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slots_mem[wr_addr] <= wr_data;
      if (cmd.mem_rd) rd_data_ff <= slots_mem[cursor_ff];
   end

   always_comb begin
      func_in       = func_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      dst_in        = dst_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      count_wide    = '0;

      if (cmd.load_req) begin
         func_in = req_func;
         pos_in  = req_position;
         val_in  = req_item_value;
      end

      // inserts walk down from the tail, deletes walk up from the target
      if (cmd.init_cursor) begin
         unique case (kind)
            KIND_INSERT: cursor_in = count_m1[AW-1:0];
            KIND_DELETE: cursor_in = target + 1'b1;
            default:     cursor_in = target;
         endcase
      end

      if (cmd.step) begin
         pend_in = 1'b1;
         if (kind == KIND_INSERT) begin
            dst_in    = cursor_ff + 1'b1;
            cursor_in = cursor_ff - 1'b1;
         end else begin
            dst_in    = cursor_ff - 1'b1;
            cursor_in = cursor_ff + 1'b1;
         end
      end

      if (cmd.drain) pend_in = 1'b0;

      if (cmd.finish) begin
         if (kind == KIND_INSERT) count_in = count_ff + 1'b1;
         else if (kind == KIND_DELETE) count_in = count_m1;
         count_wide    = {{COUNT_W{1'b0}}, count_in};
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_count_in  = count_wide[COUNT_W-1:0];
         if (kind == KIND_READ) rsp_value_in = rd_data_ff;
         else if (rv_ones) rsp_value_in = '1;
         else rsp_value_in = '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cursor_ff     <= cursor_in;
      dst_ff        <= dst_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
`default_nettype wire
